// ===== rtl/setrig_pkg.sv =====
// Shared constants, codes and types for the scan exposure trigger timer.
// No dependencies; imported by every module of the block.
package setrig_pkg;

  localparam int TICK_MS   = 5;
  localparam int FPS_PHOTO = 15;
  localparam int FPS_VIDEO = 24;

  localparam int TICK_W  = 8;
  localparam int FRAME_W = 10;
  localparam int MS_W    = 16;
  localparam int CFG_IDX_W = 2;

  // exact form of cnt * TICK_MS * fps >= 1000
  localparam int PHOTO_TICKS_I = (1000 + TICK_MS * FPS_PHOTO - 1) / (TICK_MS * FPS_PHOTO);
  localparam int VIDEO_TICKS_I = (1000 + TICK_MS * FPS_VIDEO - 1) / (TICK_MS * FPS_VIDEO);

  localparam logic [TICK_W-1:0] PHOTO_TICKS = TICK_W'(PHOTO_TICKS_I);
  localparam logic [TICK_W-1:0] VIDEO_TICKS = TICK_W'(VIDEO_TICKS_I);
  localparam logic [TICK_W-1:0] TICK_MAX    = {TICK_W{1'b1}};

  localparam logic [MS_W-1:0] START_WAIT_MS = MS_W'(666);
  localparam logic [MS_W:0]   TICK_STEP_MS  = (MS_W+1)'(TICK_MS);
  localparam logic [MS_W-1:0] MS_MAX        = {MS_W{1'b1}};

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [1:0] MODE_WIDE  = 2'd0;
  localparam logic [1:0] MODE_AREA  = 2'd1;
  localparam logic [1:0] MODE_VIDEO = 2'd2;
  localparam logic [1:0] MODE_OTHER = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_MS   = 2'd2;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [MS_W-1:0]      data;
  } cfg_wr_t;

  typedef struct packed {
    logic cmd_start;
    logic cmd_stop;
    logic still;
    logic video;
  } tick_dec_t;

  typedef struct packed {
    logic trigger;
    logic clear;
  } expo_res_t;

  typedef struct packed {
    logic position_q;
    logic position_d;
    logic running_d;
  } phase_stat_t;

endpackage

// ===== rtl/setrig_phase.sv =====
// Speed/position phase timer with its two length registers.
// Depends on setrig_pkg.
module setrig_phase import setrig_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_i,
  input  logic        tick_i,
  input  tick_dec_t   dec_i,
  output phase_stat_t stat_o
);

  logic [MS_W-1:0] speed_ms_q, pos_ms_q;
  logic            position_q, position_d;
  logic            running_q, running_d;
  logic [MS_W-1:0] elapsed_q, elapsed_d;
  logic [MS_W-1:0] length_q, length_d;

  logic            pos_a, run_a;
  logic [MS_W-1:0] el_a, len_a;
  logic [MS_W:0]   el_sum;

  always_comb begin
    el_sum = {1'b0, elapsed_q} + TICK_STEP_MS;
    pos_a  = position_q;
    len_a  = length_q;
    if (dec_i.cmd_start && dec_i.still) begin
      if (!running_q) begin
        pos_a = 1'b1;
        len_a = START_WAIT_MS;
        el_a  = '0;
        run_a = 1'b1;
      end else begin
        el_a  = el_sum[MS_W] ? MS_MAX : el_sum[MS_W-1:0];
        run_a = 1'b1;
      end
    end else begin
      el_a  = '0;
      run_a = 1'b0;
    end

    position_d = pos_a;
    length_d   = len_a;
    elapsed_d  = el_a;
    running_d  = run_a;
    if (run_a && (el_a >= len_a)) begin
      if (!pos_a) begin
        length_d   = pos_ms_q;
        position_d = 1'b1;
      end else begin
        length_d   = speed_ms_q;
        position_d = 1'b0;
      end
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_ms_q <= '0;
      pos_ms_q   <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_SPEED_MS: speed_ms_q <= cfg_i.data;
        CFG_POS_MS:   pos_ms_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= 1'b1;
      running_q  <= 1'b0;
      elapsed_q  <= '0;
      length_q   <= START_WAIT_MS;
    end else if (tick_i) begin
      position_q <= position_d;
      running_q  <= running_d;
      elapsed_q  <= elapsed_d;
      length_q   <= length_d;
    end
  end

  assign stat_o.position_q = position_q;
  assign stat_o.position_d = position_d;
  assign stat_o.running_d  = running_d;

endmodule

// ===== rtl/setrig_expo.sv =====
// Exposure interval counter and per-stripe frame counter.
// Depends on setrig_pkg; uses the phase before the tick from setrig_phase.
module setrig_expo import setrig_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_wr_t            cfg_i,
  input  logic               tick_i,
  input  tick_dec_t          dec_i,
  input  logic               position_i,
  output expo_res_t          res_o,
  output logic [FRAME_W-1:0] frames_o
);

  logic [FRAME_W-1:0] frames_max_q;
  logic [TICK_W-1:0]  tick_q, tick_d, tick_inc;
  logic [FRAME_W-1:0] stripe_q, stripe_d;

  always_comb begin
    tick_inc = (tick_q != TICK_MAX) ? tick_q + TICK_W'(1) : tick_q;
    tick_d   = tick_q;
    stripe_d = stripe_q;
    res_o    = '0;
    if (dec_i.cmd_start) begin
      if (dec_i.still) begin
        if (position_i) begin
          res_o.clear = 1'b1;
          tick_d      = '0;
          stripe_d    = '0;
        end else if (stripe_q < frames_max_q) begin
          if (tick_inc >= PHOTO_TICKS) begin
            res_o.trigger = 1'b1;
            stripe_d      = stripe_q + FRAME_W'(1);
            tick_d        = '0;
          end else begin
            tick_d = tick_inc;
          end
        end
      end else if (dec_i.video) begin
        if (tick_inc >= VIDEO_TICKS) begin
          res_o.trigger = 1'b1;
          tick_d        = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
    end else if (dec_i.cmd_stop) begin
      tick_d      = '0;
      res_o.clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_max_q <= '0;
    end else if (cfg_i.we && (cfg_i.idx == CFG_FRAMES)) begin
      frames_max_q <= cfg_i.data[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      stripe_q <= '0;
    end else if (tick_i) begin
      tick_q   <= tick_d;
      stripe_q <= stripe_d;
    end
  end

  assign frames_o = stripe_d;

endmodule

// ===== rtl/scan_exposure_trigger_timer.sv =====
// Scan exposure trigger timer, top level with the result register.
// Depends on setrig_pkg, setrig_phase and setrig_expo.
//
// Each input transaction is one tick of TICK_MS ms carrying the command and
// imaging mode. Every tick yields exactly one result transaction: trigger,
// forced clear, phase after the tick, frames done in the stripe and timer
// running flag.
// Latency: the result is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle while in_ready_o is high; all state is updated in a single pass of
// counter/compare logic between the accept edge and the result register.
// in_ready_o is high while the result register is empty or being drained,
// so a stalled receiver holds the result and stops further ticks only when
// the register is full and out_ready_i is low.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 frames per stripe, 1 speed phase ms, 2 position phase ms); write only
// while no result is pending.
// Reset: counters and settings zero, position phase with the 666 ms start
// wait loaded, timer stopped, no result pending; result data not reset.
module scan_exposure_trigger_timer import setrig_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MS_W-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [1:0]           imaging_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 exposure_trigger_o,
  output logic                 clear_exposure_o,
  output logic                 phase_is_position_o,
  output logic [FRAME_W-1:0]   frames_done_o,
  output logic                 phase_timer_running_o
);

  cfg_wr_t            cfg;
  tick_dec_t          dec;
  phase_stat_t        phase;
  expo_res_t          expo;
  logic [FRAME_W-1:0] frames;
  logic               tick;

  logic               valid_q;
  expo_res_t          expo_q;
  logic               position_q, running_q;
  logic [FRAME_W-1:0] frames_q;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  assign dec.cmd_start = (command_i == CMD_START);
  assign dec.cmd_stop  = (command_i == CMD_STOP);
  assign dec.still     = (imaging_mode_i == MODE_WIDE) || (imaging_mode_i == MODE_AREA);
  assign dec.video     = (imaging_mode_i == MODE_VIDEO);

  assign in_ready_o = !valid_q || out_ready_i;
  assign tick       = in_valid_i && in_ready_o;

  setrig_phase u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .tick_i (tick),
    .dec_i  (dec),
    .stat_o (phase)
  );

  setrig_expo u_expo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .tick_i     (tick),
    .dec_i      (dec),
    .position_i (phase.position_q),
    .res_o      (expo),
    .frames_o   (frames)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      expo_q     <= expo;
      position_q <= phase.position_d;
      running_q  <= phase.running_d;
      frames_q   <= frames;
    end
  end

  assign out_valid_o           = valid_q;
  assign exposure_trigger_o    = expo_q.trigger;
  assign clear_exposure_o      = expo_q.clear;
  assign phase_is_position_o   = position_q;
  assign frames_done_o         = frames_q;
  assign phase_timer_running_o = running_q;

endmodule

// ===== rtl/setrig_chk.sv =====
// Port-level checker for scan_exposure_trigger_timer, attached by bind.
// Depends on setrig_pkg.
module setrig_chk import setrig_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [1:0]           command_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 exposure_trigger_o,
  input logic                 clear_exposure_o,
  input logic                 phase_is_position_o,
  input logic [FRAME_W-1:0]   frames_done_o,
  input logic                 phase_timer_running_o
);

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frames_done_o)
      && $stable(exposure_trigger_o) && $stable(phase_is_position_o))
    else $error("result changed while stalled");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted tick produced no result");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == CMD_STOP)
      |=> clear_exposure_o && !exposure_trigger_o && !phase_timer_running_o)
    else $error("stop did not clear and halt the timer");

  a_trig_xor_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(exposure_trigger_o && clear_exposure_o))
    else $error("trigger and clear on the same tick");

endmodule

bind scan_exposure_trigger_timer setrig_chk u_setrig_chk (.*);

// ===== tb/sv/scan_exposure_trigger_timer_tb.sv =====
// Self-checking testbench for scan_exposure_trigger_timer: predicts each tick's result
// in a behavioral model and compares it with the block's result transactions.
// Depends on setrig_pkg and the scan_exposure_trigger_timer RTL.
module scan_exposure_trigger_timer_tb;
  import setrig_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MS_PER_S    = 1000;
  localparam int         QUIET_LIMIT = 1000;
  localparam int         SHOW_LIMIT  = 10;

  typedef struct packed {
    logic               trigger;
    logic               clear;
    logic               position;
    logic [FRAME_W-1:0] frames;
    logic               running;
  } tick_outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [MS_W-1:0]      cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           command_i = CMD_NONE;
  logic [1:0]           imaging_mode_i = MODE_WIDE;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 exposure_trigger_o;
  logic                 clear_exposure_o;
  logic                 phase_is_position_o;
  logic [FRAME_W-1:0]   frames_done_o;
  logic                 phase_timer_running_o;

  // shadow registers and timer/exposure state
  logic [FRAME_W-1:0] frame_limit = '0;
  logic [MS_W-1:0]    speed_ms = '0;
  logic [MS_W-1:0]    position_ms = '0;
  logic               in_position = 1'b1;
  logic               timer_on = 1'b0;
  int                 elapsed_ms = 0;
  int                 phase_len_ms = int'(START_WAIT_MS);
  logic [TICK_W-1:0]  interval_ticks = '0;
  logic [FRAME_W-1:0] stripe_frames = '0;

  tick_outcome_t outcome_q[$];
  tick_outcome_t want;
  int            mismatches = 0;
  int            quiet_cycles = 0;
  bit            steady = 1'b0;

  scan_exposure_trigger_timer i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .command_i             (command_i),
    .imaging_mode_i        (imaging_mode_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .exposure_trigger_o    (exposure_trigger_o),
    .clear_exposure_o      (clear_exposure_o),
    .phase_is_position_o   (phase_is_position_o),
    .frames_done_o         (frames_done_o),
    .phase_timer_running_o (phase_timer_running_o)
  );

  always #5ns clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 16);
  end

  function automatic logic frame_due(input int fps);
    if (interval_ticks < TICK_MAX) interval_ticks++;
    return int'(interval_ticks) * TICK_MS * fps >= MS_PER_S;
  endfunction

  task automatic predict_tick(input logic [1:0] cmd, input logic [1:0] mode);
    tick_outcome_t res;
    logic          still;
    res = '0;
    still = (mode == MODE_WIDE) || (mode == MODE_AREA);
    // exposure decision sees the phase from before this tick
    if (cmd == CMD_START) begin
      if (still) begin
        if (in_position) begin
          res.clear = 1'b1;
          interval_ticks = '0;
          stripe_frames = '0;
        end else if (stripe_frames < frame_limit) begin
          if (frame_due(FPS_PHOTO)) begin
            res.trigger = 1'b1;
            stripe_frames++;
            interval_ticks = '0;
          end
        end
      end else if (mode == MODE_VIDEO) begin
        if (frame_due(FPS_VIDEO)) begin
          res.trigger = 1'b1;
          interval_ticks = '0;
        end
      end
    end else if (cmd == CMD_STOP) begin
      interval_ticks = '0;
      res.clear = 1'b1;
    end
    if (cmd == CMD_START && still) begin
      if (!timer_on) begin
        in_position = 1'b1;
        phase_len_ms = int'(START_WAIT_MS);
        elapsed_ms = 0;
        timer_on = 1'b1;
      end else begin
        elapsed_ms = elapsed_ms + TICK_MS;
        if (elapsed_ms > int'(MS_MAX)) elapsed_ms = int'(MS_MAX);
      end
    end else begin
      timer_on = 1'b0;
      elapsed_ms = 0;
    end
    if (timer_on && elapsed_ms >= phase_len_ms) begin
      if (!in_position) begin
        phase_len_ms = int'(position_ms);
        in_position = 1'b1;
      end else begin
        phase_len_ms = int'(speed_ms);
        in_position = 1'b0;
      end
      elapsed_ms = 0;
    end
    res.position = in_position;
    res.frames = stripe_frames;
    res.running = timer_on;
    outcome_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [FRAME_W-1:0] exp_v,
                             input logic [FRAME_W-1:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("mismatch on %s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) $display("result transaction with none predicted");
      end else begin
        want = outcome_q.pop_front();
        check_field("exposure_trigger", FRAME_W'(want.trigger), FRAME_W'(exposure_trigger_o));
        check_field("clear_exposure", FRAME_W'(want.clear), FRAME_W'(clear_exposure_o));
        check_field("phase_is_position", FRAME_W'(want.position),
                    FRAME_W'(phase_is_position_o));
        check_field("frames_done", want.frames, frames_done_o);
        check_field("phase_timer_running", FRAME_W'(want.running),
                    FRAME_W'(phase_timer_running_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_tick(input logic [1:0] cmd, input logic [1:0] mode);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    imaging_mode_i <= mode;
    do @(posedge clk_i); while (!in_ready_o);
    predict_tick(cmd, mode);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [FRAME_W-1:0] frames, input logic [MS_W-1:0] speed,
                             input logic [MS_W-1:0] pos);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_FRAMES;
    cfg_wdata_i <= MS_W'(frames);
    frame_limit = frames;
    @(negedge clk_i);
    cfg_idx_i <= CFG_SPEED_MS;
    cfg_wdata_i <= speed;
    speed_ms = speed;
    @(negedge clk_i);
    cfg_idx_i <= CFG_POS_MS;
    cfg_wdata_i <= pos;
    position_ms = pos;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly unbroken start-photo runs; noise_pct percent of ticks are random codes
  task automatic photo_run(input int n_ticks, input int noise_pct);
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_tick(2'($urandom_range(3)), 2'($urandom_range(3)));
      else
        send_tick(CMD_START, $urandom_range(1) ? MODE_AREA : MODE_WIDE);
    end
  endtask

  task automatic test_code_matrix();
    for (int c = 0; c < 4; c++)
      for (int m = 0; m < 4; m++)
        send_tick(2'(c), 2'(m));
  endtask

  task automatic test_start_wait_and_limit();
    reconfigure(FRAME_W'(2), MS_W'(150), MS_W'(60));
    photo_run(250, 0);
  endtask

  task automatic test_zero_length_phases();
    reconfigure(FRAME_W'(FRAME_W'('1)), '0, '0);
    steady = 1'b1;
    photo_run(150, 0);
    steady = 1'b0;
  endtask

  task automatic test_long_phases();
    reconfigure(FRAME_W'('1), MS_MAX, MS_MAX);
    photo_run(200, 0);
    reconfigure('0, MS_MAX, MS_MAX);
    photo_run(100, 1);
  endtask

  task automatic test_random_stripes();
    repeat (3) begin
      reconfigure(FRAME_W'($urandom_range(12)),
                  ($urandom_range(9) == 0) ? MS_W'($urandom_range(65535))
                                           : MS_W'($urandom_range(700)),
                  MS_W'($urandom_range(300)));
      photo_run(120 + $urandom_range(120), 3);
    end
  endtask

  task automatic test_video_runs();
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(99) < 6)
        send_tick(CMD_STOP, 2'($urandom_range(3)));
      else if ($urandom_range(99) < 4)
        send_tick(CMD_START, MODE_OTHER);
      else
        send_tick(CMD_START, MODE_VIDEO);
    end
  endtask

  task automatic test_noise();
    reconfigure(FRAME_W'($urandom_range(1023)), MS_W'($urandom_range(65535)),
                MS_W'($urandom_range(65535)));
    for (int i = 0; i < 100; i++)
      send_tick(2'($urandom_range(3)), 2'($urandom_range(3)));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_code_matrix();
    test_start_wait_and_limit();
    test_zero_length_phases();
    test_long_phases();
    test_random_stripes();
    test_video_runs();
    test_noise();
    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/setrig_pkg.sv
rtl/setrig_phase.sv
rtl/setrig_expo.sv
rtl/scan_exposure_trigger_timer.sv
rtl/setrig_chk.sv
tb/sv/scan_exposure_trigger_timer_tb.sv
